### hw/rtl/ipwfd_pkg.sv
// Package for the pulse-width IR frame decoder.
// Holds the shared constants, field types and the status-priority function.
// No dependencies.
package ipwfd_pkg;

	// Frame and field geometry.
	localparam int unsigned FRAME_BITS = 16;
	localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
	localparam int unsigned TS_W       = 32;
	localparam int unsigned WIDTH_W    = 10;
	localparam int unsigned THR_W      = 11;
	localparam int unsigned SPAN_W     = 12;
	localparam int unsigned LIMIT_W    = 5;
	localparam int unsigned NIB_W      = 4;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned ENTR_W     = 2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START_MIN = 2'd0;
	localparam logic [1:0] CFG_START_MAX = 2'd1;
	localparam logic [1:0] CFG_LIMIT     = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [WIDTH_W-1:0] START_MIN_RST = 10'd140;
	localparam logic [WIDTH_W-1:0] START_MAX_RST = 10'd320;
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = 5'd16;

	// floor(t / 3) for t below 1024 is exactly (t * 683) >> 11.
	localparam int unsigned RECIP3_W     = 10;
	localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
	localparam int unsigned RECIP3_SHIFT = 11;

	// Entrance codes of the result.
	localparam logic [ENTR_W-1:0] ENTR_NORTH = 2'd1;
	localparam logic [ENTR_W-1:0] ENTR_SOUTH = 2'd2;

	// Status codes: lowest set bit of the status nibble wins.
	localparam logic [STATUS_W-1:0] ST_NONE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BIT0 = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BIT1 = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BIT2 = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BIT3 = 3'd4;

	// One decoded frame.
	typedef struct packed {
		logic [ENTR_W-1:0]   entrance;
		logic [STATUS_W-1:0] status_code;
		logic [NIB_W-1:0]    speed;
		logic [NIB_W-1:0]    unit_id;
		logic                accepted;
	} result_t;

	// Priority encode the status nibble.
	function automatic logic [STATUS_W-1:0] status_of(input logic [NIB_W-1:0] nib);
		logic [STATUS_W-1:0] code;
		priority if (nib[0]) code = ST_BIT0;
		else if (nib[1]) code = ST_BIT1;
		else if (nib[2]) code = ST_BIT2;
		else if (nib[3]) code = ST_BIT3;
		else code = ST_NONE;
		return code;
	endfunction

endpackage

### hw/rtl/ir_pulse_width_frame_decoder_unit.sv
// Top level of the pulse-width IR frame decoder: input stage, per-receiver
// decode state and result register, all in this module.
// Depends on ipwfd_pkg.
//
// Usage:
//   The slave stream carries one pin edge per item: tdata holds the 32-bit
//   microsecond timestamp and the pin level, tuser selects the receiver.
//   The two receivers (north, south) keep separate decode state, so their
//   edges may be interleaved freely.
//   The master stream carries one item per completed frame: the id, speed
//   and status fields, an accepted flag, and the entrance in tuser.
//   Edges that do not complete a frame give no output item.
// Timing:
//   An edge is registered at acceptance and decoded in the following cycle;
//   a completed frame then goes to the result register, offered on the master
//   side. One edge is taken every cycle unless a stalled result fills the input
//   stage; the per-edge work is two 32-bit subtracts and compares against the
//   stored receiver state plus a small constant multiply for the tolerance.
// Reset and stalls:
//   Reset returns both receivers to waiting for a start rise, restores the
//   configuration defaults and empties the stages. While a result waits on
//   a low m_tready the input stage holds and s_tready drops once it is full.
//   The configuration port must be written only while idle; it is not enforced.
module ir_pulse_width_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// Edge stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] timestamp, [32] level, [39:33] zero
	input  logic        s_tuser,   // [0] channel (1 north, 0 south)
	// Frame result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] accepted, [4:1] unit id, [8:5] speed,
	                               // [11:9] status_code, [15:12] zero
	output logic [1:0]  m_tuser    // [1:0] entrance
);

	localparam logic [1:0] PH_WAIT_RISE = 2'd0;
	localparam logic [1:0] PH_WAIT_FALL = 2'd1;
	localparam logic [1:0] PH_VALIDATE  = 2'd2;
	localparam logic [1:0] PH_READ      = 2'd3;

	localparam int unsigned TS_W    = ipwfd_pkg::TS_W;
	localparam int unsigned WIDTH_W = ipwfd_pkg::WIDTH_W;
	localparam int unsigned THR_W   = ipwfd_pkg::THR_W;
	localparam int unsigned SPAN_W  = ipwfd_pkg::SPAN_W;
	localparam int unsigned CNT_W   = ipwfd_pkg::CNT_W;
	localparam int unsigned NIB_W   = ipwfd_pkg::NIB_W;
	localparam int unsigned FB      = ipwfd_pkg::FRAME_BITS;
	localparam int unsigned PROD_W  = WIDTH_W + ipwfd_pkg::RECIP3_W;

	// Configuration registers.
	logic [WIDTH_W-1:0]             start_min_q;
	logic [WIDTH_W-1:0]             start_max_q;
	logic [ipwfd_pkg::LIMIT_W-1:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_min_q <= ipwfd_pkg::START_MIN_RST;
			start_max_q <= ipwfd_pkg::START_MAX_RST;
			limit_q     <= ipwfd_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipwfd_pkg::CFG_START_MIN: start_min_q <= cfg_data;
				ipwfd_pkg::CFG_START_MAX: start_max_q <= cfg_data;
				ipwfd_pkg::CFG_LIMIT:     limit_q <= cfg_data[ipwfd_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage and handshake.
	logic              valid_s1;
	logic [TS_W-1:0]   ts_s1;
	logic              level_s1;
	logic              chan_s1;
	logic              out_valid_q;
	ipwfd_pkg::result_t res_q;
	logic              advance;
	logic              s_fire;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			ts_s1    <= s_tdata[TS_W-1:0];
			level_s1 <= s_tdata[TS_W];
			chan_s1  <= s_tuser;
		end
	end

	// Per-receiver decode state, index 1 north, 0 south.
	logic [1:0]         phase_q      [2];
	logic [TS_W-1:0]    pulse_t_q    [2];
	logic [TS_W-1:0]    frame_t_q    [2];
	logic [WIDTH_W-1:0] bit_time_q   [2];
	logic [THR_W-1:0]   thr_q        [2];
	logic [FB-1:0]      frame_bits_q [2];
	logic [CNT_W-1:0]   bits_cnt_q   [2];

	// Current receiver state.
	logic [1:0]         cur_phase;
	logic [TS_W-1:0]    cur_pulse_t;
	logic [TS_W-1:0]    cur_frame_t;
	logic [WIDTH_W-1:0] cur_bit_time;
	logic [THR_W-1:0]   cur_thr;
	logic [FB-1:0]      cur_bits;
	logic [CNT_W-1:0]   cur_cnt;

	assign cur_phase    = phase_q[chan_s1];
	assign cur_pulse_t  = pulse_t_q[chan_s1];
	assign cur_frame_t  = frame_t_q[chan_s1];
	assign cur_bit_time = bit_time_q[chan_s1];
	assign cur_thr      = thr_q[chan_s1];
	assign cur_bits     = frame_bits_q[chan_s1];
	assign cur_cnt      = bits_cnt_q[chan_s1];

	// Pulse width since the last rise, and time since the start rise.
	logic [TS_W-1:0] width;
	logic [TS_W-1:0] span;
	logic            width_ok;

	assign width    = ts_s1 - cur_pulse_t;
	assign span     = ts_s1 - cur_frame_t;
	assign width_ok = (width[TS_W-1:WIDTH_W] == '0)
		&& (width[WIDTH_W-1:0] >= start_min_q)
		&& (width[WIDTH_W-1:0] <= start_max_q);

	// Start period window: 2*tau +/- floor(2*tau/6), with floor(2*tau/6) = floor(tau/3).
	logic [PROD_W-1:0] tol_prod;
	logic [SPAN_W-1:0] tol;
	logic [SPAN_W-1:0] two_tau;
	logic [SPAN_W-1:0] span_lo;
	logic [SPAN_W-1:0] span_hi;
	logic              period_ok;

	assign tol_prod  = PROD_W'(cur_bit_time) * PROD_W'(ipwfd_pkg::RECIP3);
	assign tol       = SPAN_W'(tol_prod >> ipwfd_pkg::RECIP3_SHIFT);
	assign two_tau   = {1'b0, cur_bit_time, 1'b0};
	assign span_lo   = two_tau - tol;
	assign span_hi   = two_tau + tol;
	assign period_ok = (span[TS_W-1:SPAN_W] == '0)
		&& (span[SPAN_W-1:0] >= span_lo) && (span[SPAN_W-1:0] <= span_hi);

	// Data bit: one when the pulse is longer than 1.5*tau.
	logic             data_bit;
	logic [FB-1:0]    next_bits;
	logic [CNT_W-1:0] next_cnt;
	logic             frame_done;

	assign data_bit   = (width[TS_W-1:THR_W] != '0) || (width[THR_W-1:0] > cur_thr);
	assign next_bits  = {cur_bits[FB-2:0], data_bit};
	assign next_cnt   = cur_cnt + CNT_W'(1);
	assign frame_done = valid_s1 && (cur_phase == PH_READ) && !level_s1
		&& (next_cnt >= CNT_W'(FB));

	// Frame fields and acceptance check.
	logic [NIB_W-1:0]   f_id;
	logic [NIB_W-1:0]   f_speed;
	logic [NIB_W-1:0]   f_status;
	logic [NIB_W-1:0]   f_check;
	logic [NIB_W-1:0]   want;
	ipwfd_pkg::result_t res_d;

	assign f_id     = next_bits[FB-1 -: NIB_W];
	assign f_speed  = next_bits[FB-1-NIB_W -: NIB_W];
	assign f_status = next_bits[FB-1-2*NIB_W -: NIB_W];
	assign f_check  = next_bits[NIB_W-1:0];
	assign want     = NIB_W'(0) - (f_id + f_speed + f_status);

	always_comb begin
		res_d.accepted    = (want == f_check)
			&& ({1'b0, f_id} < limit_q);
		res_d.unit_id     = f_id;
		res_d.speed       = f_speed;
		res_d.status_code = ipwfd_pkg::status_of(f_status);
		res_d.entrance    = chan_s1 ? ipwfd_pkg::ENTR_NORTH : ipwfd_pkg::ENTR_SOUTH;
	end

	// Phase update for the receiver of the edge in the input stage.
	logic       step;
	logic [1:0] phase_d;

	assign step = valid_s1 && advance;

	always_comb begin
		phase_d = cur_phase;
		unique case (cur_phase)
			PH_WAIT_RISE: if (level_s1) phase_d = PH_WAIT_FALL;
			PH_WAIT_FALL: if (!level_s1) phase_d = width_ok ? PH_VALIDATE : PH_WAIT_RISE;
			PH_VALIDATE:  if (level_s1) phase_d = period_ok ? PH_READ : PH_WAIT_RISE;
			PH_READ:      if (frame_done) phase_d = PH_WAIT_RISE;
			default:      phase_d = PH_WAIT_RISE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q[0] <= PH_WAIT_RISE;
			phase_q[1] <= PH_WAIT_RISE;
		end else if (step) begin
			phase_q[chan_s1] <= phase_d;
		end
	end

	// Timing and frame registers, written only in the phase that owns them.
	always_ff @(posedge clk) begin
		if (step) begin
			unique case (cur_phase)
				PH_WAIT_RISE: begin
					if (level_s1) begin
						pulse_t_q[chan_s1] <= ts_s1;
						frame_t_q[chan_s1] <= ts_s1;
					end
				end
				PH_WAIT_FALL: begin
					if (!level_s1 && width_ok) begin
						bit_time_q[chan_s1] <= width[WIDTH_W-1:0];
						thr_q[chan_s1] <= THR_W'(width[WIDTH_W-1:0])
							+ THR_W'(width[WIDTH_W-1:1]);
					end
				end
				PH_VALIDATE: begin
					if (level_s1 && period_ok) begin
						frame_bits_q[chan_s1] <= '0;
						bits_cnt_q[chan_s1]   <= '0;
						pulse_t_q[chan_s1]    <= ts_s1;
					end
				end
				PH_READ: begin
					if (level_s1) begin
						pulse_t_q[chan_s1] <= ts_s1;
					end else begin
						frame_bits_q[chan_s1] <= next_bits;
						bits_cnt_q[chan_s1]   <= next_cnt;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= frame_done;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_done) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, res_q.status_code, res_q.speed, res_q.unit_id, res_q.accepted};
	assign m_tuser  = res_q.entrance;

`ifndef SYNTHESIS
	// A result held by a stalled receiver must not be replaced.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

	// A result always names one of the two receivers and a legal status.
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == ipwfd_pkg::ENTR_NORTH || m_tuser == ipwfd_pkg::ENTR_SOUTH)
			&& (m_tdata[11:9] <= ipwfd_pkg::ST_BIT3)))
		else $error("malformed result");

	// The input stage only blocks while it holds an edge behind a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input blocked without a stalled result");

	// A south frame never collects more bits than its length.
	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q[0] == PH_READ) |-> (bits_cnt_q[0] < CNT_W'(FB)))
		else $error("south bit count overran the frame");
`endif

endmodule

### tb/tb_ir_pulse_width_frame_decoder_unit.sv
// Self-checking testbench for the two-receiver pulse-width IR frame decoder.
// Drives pin edges on the edge stream, predicts every decoded frame and checks
// the result stream field by field. Depends on ipwfd_pkg and the decoder top.
module tb_ir_pulse_width_frame_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 12;

	// The register index beyond the last one; writes to it must be dropped.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// Register settings and lengths of the random phases.
	localparam int N_SEG = 6;
	localparam int SEG_MIN   [N_SEG] = '{140, 0, 1023, 100, 0, 200};
	localparam int SEG_MAX   [N_SEG] = '{320, 1023, 0, 600, 1023, 260};
	localparam int SEG_LIMIT [N_SEG] = '{16, 0, 15, 8, 16, 15};
	localparam int SEG_ITEMS [N_SEG] = '{130, 130, 60, 130, 130, 80};

	// One pin edge as it travels on the edge stream.
	typedef struct packed {
		logic [31:0] ts;
		logic        level;
		logic        chan;
	} edge_t;

	typedef enum logic [1:0] {
		RX_WAIT_RISE,
		RX_WAIT_FALL,
		RX_CHECK_PERIOD,
		RX_READ_BITS
	} rx_phase_e;

	// How a directed frame is checked.
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_FRAME
	} row_check_e;

	// One directed frame: nbits of -1 sends only the start pulse, 0 the start
	// pulse and the period rise.
	typedef struct packed {
		logic               chan;
		int                 width;
		int                 span;
		logic [15:0]        bits;
		int                 nbits;
		logic               noise;
		logic               wrap;
		row_check_e         check;
		ipwfd_pkg::result_t want;
	} frame_row_t;

	localparam int N_ROWS = 14;
	// Result fields in order: entrance, status_code, speed, unit id, accepted.
	localparam frame_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{1'b1, 200, 400, 16'h0000, 16, 1'b0, 1'b0, CHK_FRAME,
			'{ipwfd_pkg::ENTR_NORTH, ipwfd_pkg::ST_NONE, 4'd0, 4'd0, 1'b1}},
		'{1'b0, 200, 400, 16'hFFFF, 16, 1'b0, 1'b0, CHK_FRAME,
			'{ipwfd_pkg::ENTR_SOUTH, ipwfd_pkg::ST_BIT0, 4'd15, 4'd15, 1'b0}},
		'{1'b1, 139, 278, 16'h0000, -1, 1'b0, 1'b0, CHK_NONE, '0},
		'{1'b0, 321, 642, 16'h0000, -1, 1'b0, 1'b0, CHK_NONE, '0},
		'{1'b1, 140, 280, 16'h1234, 16, 1'b0, 1'b0, CHK_PREDICT, '0},
		'{1'b0, 320, 640, 16'h5326, 16, 1'b0, 1'b0, CHK_FRAME,
			'{ipwfd_pkg::ENTR_SOUTH, ipwfd_pkg::ST_BIT1, 4'd3, 4'd5, 1'b1}},
		'{1'b1, 200, 333, 16'h0000, 0, 1'b0, 1'b0, CHK_NONE, '0},
		'{1'b0, 200, 467, 16'h0000, 0, 1'b0, 1'b0, CHK_NONE, '0},
		'{1'b1, 200, 334, 16'h004C, 16, 1'b0, 1'b0, CHK_FRAME,
			'{ipwfd_pkg::ENTR_NORTH, ipwfd_pkg::ST_BIT2, 4'd0, 4'd0, 1'b1}},
		'{1'b0, 200, 466, 16'h1285, 16, 1'b0, 1'b0, CHK_FRAME,
			'{ipwfd_pkg::ENTR_SOUTH, ipwfd_pkg::ST_BIT3, 4'd2, 4'd1, 1'b1}},
		'{1'b1, 250, 500, 16'hA5C3, 16, 1'b1, 1'b0, CHK_PREDICT, '0},
		'{1'b0, 200, 400, 16'hF0E1, 16, 1'b0, 1'b0, CHK_PREDICT, '0},
		'{1'b1, 200, 400, 16'hF001, 16, 1'b0, 1'b0, CHK_FRAME,
			'{ipwfd_pkg::ENTR_NORTH, ipwfd_pkg::ST_NONE, 4'd0, 4'd15, 1'b1}},
		'{1'b1, 200, 400, 16'h0000, 16, 1'b0, 1'b1, CHK_FRAME,
			'{ipwfd_pkg::ENTR_NORTH, ipwfd_pkg::ST_NONE, 4'd0, 4'd0, 1'b1}}
	};

	// Block ports.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [9:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	// Predicted decoder state, one entry per receiver.
	rx_phase_e   rx_phase  [2] = '{RX_WAIT_RISE, RX_WAIT_RISE};
	logic [31:0] pulse_t   [2];
	logic [31:0] frame_t   [2];
	logic [9:0]  tau       [2];
	logic [10:0] one_thr   [2];
	logic [15:0] shift_bits[2];
	logic [4:0]  bits_got  [2];
	logic [9:0]  lim_min   = ipwfd_pkg::START_MIN_RST;
	logic [9:0]  lim_max   = ipwfd_pkg::START_MAX_RST;
	logic [4:0]  lim_robot = ipwfd_pkg::LIMIT_RST;

	// Frames still owed by the block, oldest first.
	ipwfd_pkg::result_t frames_due[$];
	// Planned edges per receiver and the time of the last planned edge.
	edge_t       lane_q[2][$];
	logic [31:0] lane_time[2];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int results_seen = 0;
	int edges_sent = 0;
	int quiet_cycles = 0;

	ir_pulse_width_frame_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Advance the predicted receiver state by one edge.
	task automatic decode_edge(input edge_t e, output bit produced,
			output ipwfd_pkg::result_t res);
		logic [31:0] dt;
		logic [31:0] two;
		logic [31:0] tol;
		logic        c;
		logic [15:0] f;
		logic [3:0]  id;
		logic [3:0]  sp;
		logic [3:0]  st;
		logic [3:0]  want_ck;
		c = e.chan;
		produced = 1'b0;
		res = '0;
		dt = e.ts - pulse_t[c];
		case (rx_phase[c])
			RX_WAIT_RISE: begin
				if (e.level) begin
					pulse_t[c] = e.ts;
					frame_t[c] = e.ts;
					rx_phase[c] = RX_WAIT_FALL;
				end
			end
			RX_WAIT_FALL: begin
				if (!e.level) begin
					if (dt >= {22'd0, lim_min} && dt <= {22'd0, lim_max}) begin
						tau[c] = dt[9:0];
						one_thr[c] = {1'b0, dt[9:0]} + {2'b0, dt[9:1]};
						rx_phase[c] = RX_CHECK_PERIOD;
					end else begin
						rx_phase[c] = RX_WAIT_RISE;
					end
				end
			end
			RX_CHECK_PERIOD: begin
				if (e.level) begin
					dt = e.ts - frame_t[c];
					two = {21'd0, tau[c], 1'b0};
					tol = two / 6;
					if (dt >= two - tol && dt <= two + tol) begin
						shift_bits[c] = '0;
						bits_got[c] = '0;
						pulse_t[c] = e.ts;
						rx_phase[c] = RX_READ_BITS;
					end else begin
						rx_phase[c] = RX_WAIT_RISE;
					end
				end
			end
			default: begin
				if (e.level) begin
					// A second rise restarts the bit timer.
					pulse_t[c] = e.ts;
				end else begin
					shift_bits[c] = {shift_bits[c][14:0], dt > {21'd0, one_thr[c]}};
					bits_got[c] = bits_got[c] + 5'd1;
					if (bits_got[c] >= 5'(ipwfd_pkg::FRAME_BITS)) begin
						f = shift_bits[c];
						id = f[15:12];
						sp = f[11:8];
						st = f[7:4];
						want_ck = 4'd0 - id - sp - st;
						res.accepted = (want_ck == f[3:0]) && ({1'b0, id} < lim_robot);
						res.unit_id = id;
						res.speed = sp;
						casez (st)
							4'b???1: res.status_code = ipwfd_pkg::ST_BIT0;
							4'b??10: res.status_code = ipwfd_pkg::ST_BIT1;
							4'b?100: res.status_code = ipwfd_pkg::ST_BIT2;
							4'b1000: res.status_code = ipwfd_pkg::ST_BIT3;
							default: res.status_code = ipwfd_pkg::ST_NONE;
						endcase
						res.entrance = c ? ipwfd_pkg::ENTR_NORTH : ipwfd_pkg::ENTR_SOUTH;
						produced = 1'b1;
						rx_phase[c] = RX_WAIT_RISE;
					end
				end
			end
		endcase
	endtask

	// Lay out the edges of one frame on a receiver's lane. Noise adds an edge
	// of the wrong level in every phase.
	task automatic plan_frame(input logic ch, input int width, input int span,
			input logic [15:0] bits, input int nbits, input bit noise, input bit wrap);
		logic [31:0] t;
		logic [31:0] p;
		int          thr_g;
		int          pw;
		int          k;
		thr_g = width + width / 2;
		if (wrap) begin
			t = 32'hFFFF_FFFF - 32'($urandom_range(0, 4 * width + 64));
		end else begin
			t = lane_time[ch] + 32'($urandom_range(1, 5000));
		end
		if (noise) lane_q[ch].push_back('{t - 32'd1, 1'b0, ch});
		lane_q[ch].push_back('{t, 1'b1, ch});
		if (noise) lane_q[ch].push_back('{t + 32'(width / 2), 1'b1, ch});
		lane_q[ch].push_back('{t + 32'(width), 1'b0, ch});
		if (noise) lane_q[ch].push_back('{t + 32'(width + 1), 1'b0, ch});
		p = t + 32'(span);
		if (nbits >= 0) lane_q[ch].push_back('{p, 1'b1, ch});
		for (k = 0; k < nbits; k++) begin
			if (bits[15 - k]) begin
				pw = thr_g + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, width));
			end else begin
				pw = ($urandom_range(0, 3) == 0) ? thr_g : $urandom_range(0, thr_g);
			end
			if (noise && k == 5) lane_q[ch].push_back('{p + 32'(pw / 3), 1'b1, ch});
			lane_q[ch].push_back('{p + 32'(pw), 1'b0, ch});
			p = p + 32'(pw);
			if (k < nbits - 1) begin
				p = p + 32'($urandom_range(1, 2 * width + 1));
				lane_q[ch].push_back('{p, 1'b1, ch});
			end
		end
		lane_time[ch] = (nbits < 0) ? t + 32'(width) : p;
	endtask

	// Pick a frame for the current bounds: mostly well formed, some broken.
	task automatic plan_random_frame(input logic ch);
		int         lo;
		int         hi;
		int         width;
		int         two;
		int         tol;
		int         span;
		int         nbits;
		int         r;
		bit         noise;
		logic [3:0] id;
		logic [3:0] sp;
		logic [3:0] st;
		logic [3:0] ck;
		lo = int'(lim_min);
		hi = int'(lim_max);
		if (lo > hi) begin
			lo = 0;
			hi = 1023;
		end
		case ($urandom_range(0, 9))
			0: width = lo;
			1: width = hi;
			default: width = $urandom_range(lo, hi);
		endcase
		two = 2 * width;
		tol = two / 6;
		if ($urandom_range(0, 4) == 0) begin
			span = $urandom_range(0, 1) ? two - tol : two + tol;
		end else begin
			span = $urandom_range(two - tol, two + tol);
		end
		nbits = 16;
		noise = 1'b0;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// Start pulse outside the bounds.
			nbits = -1;
			if (lo > 0 && $urandom_range(0, 1)) width = $urandom_range(0, lo - 1);
			else width = hi + 1 + $urandom_range(0, 40);
		end else if (r < 16) begin
			// Start period just outside the tolerance on either side.
			nbits = 0;
			span = $urandom_range(0, 1) ? two - tol - 1 : two + tol + 1 + $urandom_range(0, 3);
		end else if (r < 20) begin
			nbits = $urandom_range(1, 15);
		end else if (r < 30) begin
			noise = 1'b1;
		end
		id = 4'($urandom);
		sp = 4'($urandom);
		st = 4'($urandom);
		ck = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0 - id - sp - st;
		plan_frame(ch, width, span, {id, sp, st, ck}, nbits, noise, $urandom_range(0, 19) == 0);
	endtask

	// Offer one edge, wait for the handshake and predict its effect.
	task automatic feed_edge(input edge_t e, output bit produced,
			output ipwfd_pkg::result_t res);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, e.level, e.ts};
		s_tuser <= e.chan;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		edges_sent++;
		decode_edge(e, produced, res);
	endtask

	// Stop offering and wait until every owed frame has come out.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 10'(val);
		@(posedge clk);
		case (idx)
			ipwfd_pkg::CFG_START_MIN: lim_min = 10'(val);
			ipwfd_pkg::CFG_START_MAX: lim_max = 10'(val);
			ipwfd_pkg::CFG_LIMIT:     lim_robot = 5'(val);
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int min_w, input int max_w, input int limit);
		write_reg(ipwfd_pkg::CFG_START_MIN, min_w);
		write_reg(ipwfd_pkg::CFG_START_MAX, max_w);
		write_reg(ipwfd_pkg::CFG_LIMIT, limit);
		write_reg(CFG_SPARE, 1023);
		cfg_we <= 1'b0;
	endtask

	// Result checker and watchdog.
	always @(posedge clk) begin
		ipwfd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				report_mismatch("result with no frame due, unit id", int'(m_tdata[4:1]), -1);
			end else begin
				want = frames_due.pop_front();
				if (m_tdata[0] !== want.accepted)
					report_mismatch("accepted", int'(m_tdata[0]), int'(want.accepted));
				if (m_tdata[4:1] !== want.unit_id)
					report_mismatch("unit id", int'(m_tdata[4:1]), int'(want.unit_id));
				if (m_tdata[8:5] !== want.speed)
					report_mismatch("speed", int'(m_tdata[8:5]), int'(want.speed));
				if (m_tdata[11:9] !== want.status_code)
					report_mismatch("status_code", int'(m_tdata[11:9]), int'(want.status_code));
				if (m_tuser !== want.entrance)
					report_mismatch("entrance", int'(m_tuser), int'(want.entrance));
			end
			results_seen++;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles, %0d frames still due",
					QUIET_LIMIT, frames_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Result receiver: random back-pressure plus one long hold-off.
	initial begin : receiver
		int  hold;
		bit  held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Stimulus: directed frames at the reset settings, then random phases.
	initial begin : stimulus
		edge_t              e;
		frame_row_t         row;
		ipwfd_pkg::result_t res;
		bit                 produced;
		int                 seg;
		int                 count;
		int                 i;
		logic               ch;
		lane_time[0] = $urandom;
		lane_time[1] = $urandom;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 77;
		for (i = 0; i < N_ROWS; i++) begin
			row = DIRECTED_ROWS[i];
			plan_frame(row.chan, row.width, row.span, row.bits, row.nbits, row.noise, row.wrap);
			while (lane_q[row.chan].size() != 0) begin
				e = lane_q[row.chan].pop_front();
				feed_edge(e, produced, res);
				if (row.check == CHK_PREDICT && produced) frames_due.push_back(res);
			end
			if (row.check == CHK_FRAME) frames_due.push_back(row.want);
		end
		drain();

		for (seg = 0; seg < N_SEG; seg++) begin
			// Idle pattern: sender light and receiver heavy, then swapped, then none.
			send_idle_pct = (seg < 2) ? 20 : (seg < 4) ? 77 : 0;
			recv_idle_pct = (seg < 2) ? 77 : (seg < 4) ? 20 : 0;
			apply_settings(SEG_MIN[seg], SEG_MAX[seg], SEG_LIMIT[seg]);
			count = 0;
			while (count < SEG_ITEMS[seg]) begin
				ch = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 3) begin
					e = '{$urandom, 1'($urandom), 1'($urandom)};
				end else begin
					if (lane_q[ch].size() == 0) plan_random_frame(ch);
					e = lane_q[ch].pop_front();
				end
				feed_edge(e, produced, res);
				if (produced) frames_due.push_back(res);
				count++;
			end
			drain();
		end

		$display("Covered %0d edges on both receivers over %0d register settings,",
			edges_sent, N_SEG + 1);
		$display("with %0d decoded frames checked and %0d mismatches.",
			results_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
